@@ rtl/slva_pkg.sv @@
`timescale 1ns / 1ps

package slva_pkg;

  localparam int unsigned ReadingW = 10;
  localparam int unsigned RawW = 12;
  localparam int unsigned SpanW = 10;
  localparam int unsigned GroundW = 11;
  localparam int unsigned PctW = 18;
  localparam int unsigned ProdW = 17;

  localparam logic [SpanW-1:0] SPAN_RESET = 10'd248;
  localparam logic [ProdW-1:0] PCT_SCALE = 17'd100;
  localparam logic signed [GroundW-1:0] GROUND_UNSET = -11'sd1;

  // Item kinds carried on tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic sample_upd;
    logic mean_take;
    logic scale_take;
    logic div_start;
    logic load_out;
  } slva_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_compute;
    logic keep;
    logic div_done;
  } slva_stat_t;

endpackage

@@ rtl/slva_div.sv @@
`timescale 1ns / 1ps

module slva_div import slva_pkg::*; #(
  parameter int unsigned DW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [SpanW-1:0] divisor_i,
  output logic             done_o,
  output logic [DW-1:0]    quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]    quot_q, quot_d;
  logic [SpanW-1:0] rem_q, rem_d;
  logic [SpanW-1:0] dvs_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SpanW:0]   trial;
  logic             ge;

  // One quotient bit per cycle, restoring form
  always_comb begin
    trial = {rem_q, quot_q[DW-1]};
    ge = trial >= {1'b0, dvs_q};
    quot_d = quot_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      cnt_d = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[DW-2:0], ge};
      rem_d = ge ? SpanW'(trial - {1'b0, dvs_q}) : trial[SpanW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/slva_dp.sv @@
`timescale 1ns / 1ps

module slva_dp import slva_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slva_cmd_t           cmd_i,
  output slva_stat_t          stat_o,
  input  logic                kind_i,
  input  logic [RawW-1:0]     reading_i,
  input  logic                motor_off_i,
  input  logic                cfg_we_i,
  input  logic [SpanW-1:0]    cfg_data_i,
  output logic [PctW-1:0]     altitude_percent_o,
  output logic [ReadingW-1:0] mean_level_o
);

  localparam int unsigned AW = $clog2(WINDOW_LEN);
  localparam int unsigned SW = ReadingW + AW;
  localparam int unsigned LW = $clog2(2 * WINDOW_LEN);
  localparam logic [LW-1:0] LandedMax = LW'(2 * WINDOW_LEN - 1);
  // Mean by reciprocal multiply: exact for every sum below 2**SW
  localparam int unsigned RecipShift = SW + AW;
  localparam int unsigned RecipW = SW + 1;
  localparam int unsigned MulW = SW + RecipW;
  localparam logic [RecipW-1:0] MeanRecip =
    RecipW'(((64'd1 << RecipShift) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [ReadingW-1:0] store_q [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] valid_q;
  logic [ReadingW-1:0] rd_q;
  logic                rd_valid_q;

  logic                kind_q;
  logic [RawW-1:0]     reading_q;
  logic                motor_q;
  logic [SpanW-1:0]    span_q;
  logic [AW-1:0]       slot_q;
  logic [SW-1:0]       sum_q;
  logic [LW-1:0]       landed_q;
  logic signed [GroundW-1:0] ground_q;
  logic [ReadingW-1:0] mean_q;
  logic [ProdW-1:0]    prod_q;
  logic                neg_q;
  logic [PctW-1:0]     out_pct_q;
  logic [ReadingW-1:0] out_mean_q;

  logic [ProdW-1:0]    div_dividend;
  logic [SpanW-1:0]    div_divisor;
  logic                div_done;
  logic [ProdW-1:0]    div_quot;

  logic [ReadingW-1:0] old_val;
  logic [MulW-1:0]     mean_prod;
  logic [ReadingW-1:0] mean_w;
  logic                recal;
  logic signed [GroundW-1:0] ground_new;
  logic signed [GroundW:0]   diff;
  logic [GroundW-1:0]  mag;
  logic [ProdW-1:0]    quot_mag;
  logic [PctW-1:0]     pct_w;

  assign old_val = rd_valid_q ? rd_q : '0;
  assign mean_prod = MulW'(sum_q) * MulW'(MeanRecip);
  assign mean_w = mean_prod[RecipShift +: ReadingW];
  assign recal = (landed_q > LW'(WINDOW_LEN)) && (mean_q > span_q);
  assign ground_new = recal ? $signed({1'b0, mean_q}) : ground_q;
  assign diff = {ground_new[GroundW-1], ground_new} - $signed({2'b00, mean_q});
  assign mag = diff[GroundW] ? GroundW'(-diff) : diff[GroundW-1:0];
  assign quot_mag = div_quot[ProdW-1:0];
  assign pct_w = neg_q ? PctW'(-{1'b0, quot_mag}) : {1'b0, quot_mag};

  assign div_dividend = prod_q;
  assign div_divisor = (span_q == '0) ? SpanW'(1) : span_q;

  slva_div #(.DW(ProdW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Window ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_upd) begin
      store_q[slot_q] <= reading_q[ReadingW-1:0];
    end
    if (cmd_i.mem_read) begin
      rd_q <= store_q[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_valid_q <= 1'b0;
      span_q <= SPAN_RESET;
      slot_q <= '0;
      sum_q <= '0;
      landed_q <= '0;
      ground_q <= GROUND_UNSET;
    end else begin
      if (cfg_we_i) begin
        span_q <= cfg_data_i;
      end
      if (cmd_i.mem_read) begin
        rd_valid_q <= valid_q[slot_q];
      end
      if (cmd_i.sample_upd) begin
        valid_q[slot_q] <= 1'b1;
        sum_q <= sum_q - SW'(old_val) + SW'(reading_q[ReadingW-1:0]);
        slot_q <= (slot_q == AW'(WINDOW_LEN - 1)) ? '0 : slot_q + AW'(1);
        if (motor_q) begin
          landed_q <= (landed_q == LandedMax) ? landed_q : landed_q + LW'(1);
        end else begin
          landed_q <= '0;
        end
        if (ground_q == GROUND_UNSET) begin
          ground_q <= $signed({1'b0, reading_q[ReadingW-1:0]});
        end
      end
      if (cmd_i.scale_take) begin
        ground_q <= ground_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      reading_q <= reading_i;
      motor_q <= motor_off_i;
    end
    if (cmd_i.mean_take) begin
      mean_q <= mean_w;
    end
    if (cmd_i.scale_take) begin
      neg_q <= diff[GroundW];
      prod_q <= ProdW'(mag) * PCT_SCALE;
    end
    if (cmd_i.load_out) begin
      out_pct_q <= pct_w;
      out_mean_q <= mean_q;
    end
  end

  assign stat_o.is_compute = (kind_q == KIND_COMPUTE);
  assign stat_o.keep = (reading_q[RawW-1:ReadingW] == '0);
  assign stat_o.div_done = div_done;

  assign altitude_percent_o = out_pct_q;
  assign mean_level_o = out_mean_q;

endmodule

@@ rtl/slva_ctrl.sv @@
`timescale 1ns / 1ps

module slva_ctrl import slva_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  slva_stat_t stat_i,
  output slva_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_SUPD   = 7'b0000100,
    ST_MEAN   = 7'b0001000,
    ST_SCALE  = 7'b0010000,
    ST_PDIV   = 7'b0100000,
    ST_FIN    = 7'b1000000
  } slva_state_e;

  slva_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.is_compute) begin
          cmd_o.mean_take = 1'b1;
          state_d = ST_MEAN;
        end else if (stat_i.keep) begin
          cmd_o.mem_read = 1'b1;
          state_d = ST_SUPD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUPD: begin
        cmd_o.sample_upd = 1'b1;
        state_d = ST_IDLE;
      end
      ST_MEAN: begin
        cmd_o.scale_take = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_PDIV;
      end
      ST_PDIV: begin
        if (stat_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/self_calibrating_level_averager.sv @@
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                        | Payload
// ----------+-----+----------------------------------+--------------------------------------
// s_axis    | in  | s_axis_tvalid_i / s_axis_tready_o | tuser: kind; tdata: reading, motor_off
// m_axis    | out | m_axis_tvalid_o / m_axis_tready_i | tdata: altitude_percent, mean_level
// cfg       | in  | cfg_valid_i / cfg_ready_o         | cfg_data_i: span
//
// One beat at a time: a sample beat is decoded and, when kept, read from the window then updated.
// A compute beat takes the window mean by reciprocal multiply, scales its distance from ground
// by 100, then divides by span serially over 17 quotient bits.
// The finished result sits in an output register, so the next beat is taken while it waits;
// a second compute result holds in the last state until that register frees up.
// Reset clears the window at once through per-entry valid bits; no clearing pass.
module self_calibrating_level_averager import slva_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] adc_reading, [12] motor_off, [15:13] zero
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [17:0] altitude_percent, [27:18] mean_level, zero above
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i        // span
);

  slva_cmd_t           cmd;
  slva_stat_t          stat;
  logic [PctW-1:0]     altitude_percent;
  logic [ReadingW-1:0] mean_level;

  // Span writes land in any cycle; a write during a compute beat can change its result
  assign cfg_ready_o = 1'b1;

  slva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  slva_dp #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .kind_i             (s_axis_tuser_i),
    .reading_i          (s_axis_tdata_i[RawW-1:0]),
    .motor_off_i        (s_axis_tdata_i[RawW]),
    .cfg_we_i           (cfg_valid_i & cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .altitude_percent_o (altitude_percent),
    .mean_level_o       (mean_level)
  );

  // Pack the result beat, percent in the low bits
  assign m_axis_tdata_o = {4'b0000, mean_level, altitude_percent};

endmodule

@@ rtl/slva_chk.sv @@
`timescale 1ns / 1ps

module slva_chk import slva_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // One beat in flight: input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while previous beat still in work");

  // A sample beat never raises a result
  a_sample_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == KIND_SAMPLE) && !m_axis_tvalid_o
    |=> !m_axis_tvalid_o)
    else $error("result raised by a sample beat");

  // Padding above the mean stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[31:28] == 4'b0000))
    else $error("result padding not zero");

endmodule

bind self_calibrating_level_averager slva_chk u_slva_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
